[design/pfd_pkg.sv]
package pfd_pkg;

  localparam int unsigned BlockSizeDef = 32;
  localparam int unsigned NumWidths    = 15;
  localparam int unsigned RawIndex     = 14;
  localparam logic [5:0]  ExcLimitRst  = 6'd3;

  // exception value size codes in the header
  localparam logic [1:0]  TypeByte     = 2'd0;
  localparam logic [1:0]  TypeHalf     = 2'd1;
  localparam logic [1:0]  TypeWord     = 2'd2;

  // slot width for each table index
  function automatic logic [5:0] width_of(input logic [3:0] k);
    logic [5:0] w;
    case (k)
      4'd12:   w = 6'd16;
      4'd13:   w = 6'd20;
      4'd14:   w = 6'd32;
      default: w = {2'b00, k} + 6'd2;
    endcase
    return w;
  endfunction

endpackage

[design/pfordelta_block_encoder_core.sv]
// Channel | Direction | Ports
// in      | input     | in_valid, in_stall (out), in_value, in_end_of_stream
// out     | output    | out_valid, out_stall (in), out_word, out_last_word
// cfg     | input     | cfg_valid, cfg_ready (out), cfg_exception_limit
// A value that does not close a block is stored and in_stall stays low.
// A short final block is first zero padded, entry by entry.
// Each width tried reads and tests every element, then decides, for up to
// 14 widths; then the header, the slots and the exceptions are sent, or the
// raw block, and any output stall holds the sequence.
// Reset is synchronous (rst_n low); every memory entry is written before read.
// in_stall is high from the closing transfer until the last word is loaded.
module pfordelta_block_encoder_core
  import pfd_pkg::*;
#(
  parameter int unsigned BLOCK_SIZE = BlockSizeDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word,
  output logic        out_last_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_exception_limit
);

  localparam int unsigned AW = $clog2(BLOCK_SIZE);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_PAD   = 8'b00000010,
    S_SCAN  = 8'b00000100,
    S_TAIL  = 8'b00001000,
    S_HDR   = 8'b00010000,
    S_SLOT  = 8'b00100000,
    S_EXC   = 8'b01000000,
    S_RAW   = 8'b10000000
  } state_t;

  state_t state_r;

  logic [31:0]   blk_mem  [BLOCK_SIZE];
  logic [31:0]   slot_mem [BLOCK_SIZE];
  logic [31:0]   exc_mem  [BLOCK_SIZE];

  logic [5:0]    limit_r;
  logic [CW-1:0] fill_r;
  logic [31:0]   maxv_r;
  logic [AW-1:0] idx_r;       // element pointer
  logic          phase_r;     // read data valid
  logic [3:0]    k_r;
  logic [CW-1:0] nexc_r;
  logic          have_r;
  logic [AW-1:0] last_r;
  logic [CW-1:0] start_r;
  logic [CW-1:0] eidx_r;      // exception pointer
  logic [31:0]   rd_r;
  logic [31:0]   srd_r;
  logic [31:0]   erd_r;
  // packer
  logic [31:0]   acc_r;
  logic [5:0]    accn_r;      // bits held in acc
  logic          ov_r;
  logic [31:0]   ow_r;
  logic          olast_r;

  logic [5:0]    b;
  logic [5:0]    bb;
  logic [1:0]    tcode;
  logic          in_acc;
  logic          out_free;
  logic          blk_close;
  logic          idx_last;
  logic          exc_last;
  logic [31:0]   lim;
  logic [CW-1:0] gap;
  logic          is_exc;
  logic          scan_hit;
  logic [31:0]   sw_n;
  logic [31:0]   ew_n;
  logic          reject;
  logic [31:0]   hdr_word;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          slot_we;
  logic [AW-1:0] slot_waddr;
  logic [31:0]   slot_wdata;
  logic          exc_we;

  logic [31:0]   pk_fld;
  logic [5:0]    pk_w;
  logic [6:0]    pk_tot;
  logic [6:0]    pk_sh;
  logic [63:0]   pk_cat;
  logic [63:0]   pk_hi;
  logic [63:0]   pk_lo;
  logic          pk_full;
  logic [31:0]   pk_rem;

  logic          emit;
  logic [31:0]   emit_word;
  logic          emit_last;

  assign b = width_of(k_r);

  assign in_stall      = (state_r != S_IDLE);
  assign in_acc        = in_valid && !in_stall;
  assign cfg_ready     = (state_r == S_IDLE);
  assign out_valid     = ov_r;
  assign out_word      = ow_r;
  assign out_last_word = olast_r;
  assign out_free      = !ov_r || !out_stall;

  assign blk_close = (fill_r == CW'(BLOCK_SIZE - 1)) || in_end_of_stream;
  assign idx_last  = (idx_r == AW'(BLOCK_SIZE - 1));
  assign exc_last  = (eidx_r + CW'(1) == nexc_r);

  // exception value size from the block maximum
  always_comb begin
    if (maxv_r < 32'd256) begin
      bb = 6'd8;
      tcode = TypeByte;
    end else if (maxv_r < 32'd65536) begin
      bb = 6'd16;
      tcode = TypeHalf;
    end else begin
      bb = 6'd32;
      tcode = TypeWord;
    end
  end

  // exception test of the element just read
  assign lim      = 32'd1 << b;
  assign gap      = {1'b0, idx_r} - {1'b0, last_r};
  assign is_exc   = (rd_r >= lim) || (have_r && (32'(gap) == lim));
  assign scan_hit = (state_r == S_SCAN) && phase_r;

  // word counts for the width decision
  assign sw_n   = 32'(b) * 32'(BLOCK_SIZE / 32);
  assign ew_n   = (32'(bb) * 32'(nexc_r) + 32'd31) >> 5;
  assign reject = (32'(nexc_r) > 32'(limit_r)) || (sw_n + ew_n > 32'(BLOCK_SIZE));

  assign hdr_word = (k_r == 4'(RawIndex)) ?
      ((32'(RawIndex) << 12) | (32'(TypeWord) << 10) | 32'(BLOCK_SIZE)) :
      ((32'(k_r) << 12) | (32'(tcode) << 10) | 32'(start_r));

  // block store: loading and zero padding
  assign mem_we    = (state_r == S_PAD) || in_acc;
  assign mem_waddr = (state_r == S_PAD) ? idx_r : fill_r[AW-1:0];
  assign mem_wdata = (state_r == S_PAD) ? 32'd0 : in_value;

  // slot store: plain values, chain gaps, and the end marker of the chain
  assign slot_we    = (scan_hit && !(is_exc && !have_r)) || ((state_r == S_TAIL) && have_r);
  assign slot_waddr = ((state_r == S_TAIL) || is_exc) ? last_r : idx_r;
  assign slot_wdata = (state_r == S_TAIL) ? (lim - 32'd1) :
                      (is_exc ? 32'(gap - CW'(1)) : rd_r);
  assign exc_we     = scan_hit && is_exc;

  always_ff @(posedge clk) begin
    if (mem_we) blk_mem[mem_waddr] <= mem_wdata;
    rd_r <= blk_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    srd_r <= slot_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (exc_we) exc_mem[nexc_r[AW-1:0]] <= rd_r;
    erd_r <= exc_mem[eidx_r[AW-1:0]];
  end

  // shared bit packer: append one field MSB-first
  assign pk_fld  = (state_r == S_EXC) ? erd_r : srd_r;
  assign pk_w    = (state_r == S_EXC) ? bb : b;
  assign pk_tot  = {1'b0, accn_r} + {1'b0, pk_w};
  assign pk_sh   = pk_tot - 7'd32;
  assign pk_cat  = ({32'd0, acc_r} << pk_w) | {32'd0, pk_fld};
  assign pk_full = (pk_tot >= 7'd32);
  assign pk_hi   = pk_cat >> pk_sh;
  assign pk_lo   = pk_cat << (7'd32 - pk_tot);
  assign pk_rem  = pk_cat[31:0] & ~(32'hFFFF_FFFF << pk_sh);

  // word handed to the output register
  always_comb begin
    emit      = 1'b0;
    emit_word = pk_hi[31:0];
    emit_last = 1'b0;
    unique case (state_r)
      S_HDR: begin
        emit      = out_free;
        emit_word = hdr_word;
      end
      S_SLOT: begin
        if (phase_r && pk_full) begin
          emit      = out_free;
          emit_last = (nexc_r == '0) && idx_last;
        end
      end
      S_EXC: begin
        if (phase_r && (exc_last || pk_full)) begin
          emit      = out_free;
          emit_word = exc_last ? pk_lo[31:0] : pk_hi[31:0];
          emit_last = exc_last;
        end
      end
      S_RAW: begin
        if (phase_r) begin
          emit      = out_free;
          emit_word = rd_r;
          emit_last = idx_last;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ow_r    <= emit_word;
      olast_r <= emit_last;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= ExcLimitRst;
      fill_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) limit_r <= cfg_exception_limit;
      unique case (state_r)
        S_IDLE: begin
          k_r     <= '0;
          phase_r <= 1'b0;
          nexc_r  <= '0;
          have_r  <= 1'b0;
          last_r  <= '0;
          start_r <= CW'(BLOCK_SIZE);
          if (in_acc) begin
            maxv_r <= (fill_r == '0 || in_value > maxv_r) ? in_value : maxv_r;
            if (blk_close) begin
              fill_r <= '0;
              if (fill_r == CW'(BLOCK_SIZE - 1)) begin
                idx_r   <= '0;
                state_r <= S_SCAN;
              end else begin
                idx_r   <= AW'(fill_r + CW'(1));
                state_r <= S_PAD;
              end
            end else begin
              fill_r <= fill_r + CW'(1);
            end
          end
        end
        S_PAD: begin
          if (idx_last) begin
            idx_r   <= '0;
            state_r <= S_SCAN;
          end else begin
            idx_r <= idx_r + AW'(1);
          end
        end
        S_SCAN: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else begin
            if (is_exc) begin
              if (!have_r) start_r <= {1'b0, idx_r};
              have_r <= 1'b1;
              last_r <= idx_r;
              nexc_r <= nexc_r + CW'(1);
            end
            phase_r <= 1'b0;
            if (idx_last) state_r <= S_TAIL;
            else idx_r <= idx_r + AW'(1);
          end
        end
        S_TAIL: begin
          idx_r <= '0;
          if (reject) begin
            nexc_r  <= '0;
            have_r  <= 1'b0;
            last_r  <= '0;
            start_r <= CW'(BLOCK_SIZE);
            k_r     <= k_r + 4'd1;
            state_r <= (k_r == 4'(RawIndex - 1)) ? S_HDR : S_SCAN;
          end else begin
            state_r <= S_HDR;
          end
        end
        S_HDR: begin
          if (out_free) begin
            idx_r   <= '0;
            phase_r <= 1'b0;
            acc_r   <= '0;
            accn_r  <= '0;
            eidx_r  <= '0;
            state_r <= (k_r == 4'(RawIndex)) ? S_RAW : S_SLOT;
          end
        end
        S_SLOT: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else if (!pk_full || out_free) begin
            acc_r   <= pk_full ? pk_rem : pk_cat[31:0];
            accn_r  <= pk_full ? pk_sh[5:0] : pk_tot[5:0];
            phase_r <= 1'b0;
            // slot bits fill whole words, so the packer is empty here
            if (idx_last) state_r <= (nexc_r == '0) ? S_IDLE : S_EXC;
            else idx_r <= idx_r + AW'(1);
          end
        end
        S_EXC: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else if (exc_last) begin
            if (out_free) state_r <= S_IDLE;
          end else if (!pk_full || out_free) begin
            acc_r   <= pk_full ? pk_rem : pk_cat[31:0];
            accn_r  <= pk_full ? pk_sh[5:0] : pk_tot[5:0];
            eidx_r  <= eidx_r + CW'(1);
            phase_r <= 1'b0;
          end
        end
        S_RAW: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else if (out_free) begin
            phase_r <= 1'b0;
            if (idx_last) state_r <= S_IDLE;
            else idx_r <= idx_r + AW'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import pfd_pkg::*;

  localparam int BLK = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 60;

  // slot widths by table index
  localparam int SLOT_W [0:14] = '{2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 16, 20, 32};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_value;
  logic        in_end_of_stream;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_word;
  logic        out_last_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [5:0]  cfg_exception_limit;

  pfordelta_block_encoder_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_value           (in_value),
    .in_end_of_stream   (in_end_of_stream),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_word           (out_word),
    .out_last_word      (out_last_word),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_exception_limit(cfg_exception_limit)
  );

  // predictor state
  logic [31:0] blk_vals [BLK];
  int          blk_fill;
  logic [5:0]  exc_limit;
  logic [31:0] pack_buf [BLK+1];
  logic [31:0] exp_words [$];
  logic        exp_lasts [$];

  int  errors, items_sent, blocks_done, words_seen, idle_count;
  int  holdoff;
  bit  quiet;
  int  stall_burst;

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // MSB-first bit packing into pack_buf
  function automatic void put_field(int pos, logic [31:0] val, int w);
    for (int j = w; j > 0; j--) begin
      if (val[j-1]) pack_buf[pos >> 5][31 - (pos & 31)] = 1'b1;
      pos++;
    end
  endfunction

  // pick first acceptable width and queue the encoded words
  function automatic void encode_block();
    logic [31:0] slots [BLK];
    logic [31:0] excs [BLK];
    logic [31:0] maxv, lim;
    int b, bb, t, n, last, first, sw, ew, cnt;
    bit have;
    cnt = 0;
    for (int k = 0; k < 15 && cnt == 0; k++) begin
      b = SLOT_W[k];
      if (b == 32) begin
        pack_buf[0] = (32'(k) << 12) | (32'd2 << 10) | 32'(BLK);
        for (int i = 0; i < BLK; i++) pack_buf[1+i] = blk_vals[i];
        cnt = BLK + 1;
      end else begin
        maxv = 0;
        for (int i = 0; i < BLK; i++) if (blk_vals[i] > maxv) maxv = blk_vals[i];
        if (maxv < 256) begin bb = 8; t = 0; end
        else if (maxv < 65536) begin bb = 16; t = 1; end
        else begin bb = 32; t = 2; end
        lim = 32'd1 << b;
        n = 0; last = 0; first = BLK; have = 0;
        for (int i = 0; i < BLK; i++) begin
          if (blk_vals[i] >= lim || (have && 32'(i - last) == lim)) begin
            if (!have) first = i;
            else slots[last] = 32'(i - last - 1);
            excs[n++] = blk_vals[i];
            last = i;
            have = 1;
          end else begin
            slots[i] = blk_vals[i];
          end
        end
        if (have) slots[last] = lim - 1;
        sw = (b * BLK + 31) >> 5;
        ew = (bb * n + 31) >> 5;
        if (n <= int'(exc_limit) && 1 + sw + ew <= BLK + 1) begin
          for (int i = 0; i <= BLK; i++) pack_buf[i] = '0;
          pack_buf[0] = (32'(k) << 12) | (32'(t) << 10) | 32'(first);
          for (int i = 0; i < BLK; i++) put_field(32 + i * b, slots[i], b);
          for (int i = 0; i < n; i++) put_field(32 * (1 + sw) + i * bb, excs[i], bb);
          cnt = 1 + sw + ew;
        end
      end
    end
    for (int i = 0; i < cnt; i++) begin
      exp_words.push_back(pack_buf[i]);
      exp_lasts.push_back(i == cnt - 1);
    end
    blocks_done++;
  endfunction

  function automatic void predict_value(logic [31:0] v, logic eos);
    if (blk_fill >= BLK) blk_fill = 0;
    blk_vals[blk_fill] = v;
    blk_fill++;
    if (blk_fill == BLK || eos) begin
      for (int i = blk_fill; i < BLK; i++) blk_vals[i] = '0;
      blk_fill = 0;
      encode_block();
    end
  endfunction

  // send one value, with an optional random gap first; valid stays high after
  task automatic send_value(logic [31:0] v, logic eos);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_value         <= v;
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
    predict_value(v, eos);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    wait (exp_words.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [5:0] lim);
    drain();
    @(negedge clk);
    cfg_valid           <= 1'b1;
    cfg_exception_limit <= lim;
    do @(posedge clk); while (!cfg_ready);
    exc_limit = lim;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // value drawn from a spread of magnitudes
  function automatic logic [31:0] rand_value(int mode);
    int w;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        w = $urandom_range(0, mode);
        rand_value = $urandom & ((32'd1 << w) - 1);
      end
      4: rand_value = (32'd1 << $urandom_range(1, 31)) - $urandom_range(0, 1);
      5: rand_value = $urandom & 32'hFFFF;
      6: rand_value = $urandom & 32'hFFFFF;
      7: rand_value = $urandom;
      default: rand_value = '0;
    endcase
  endfunction

  task automatic send_block(int len, int mode);
    logic [31:0] v;
    for (int i = 0; i < len; i++) begin
      if (mode < 0) v = rand_value(13);
      else if ($urandom_range(0, 15) == 0) v = rand_value(13);
      else v = $urandom & ((32'd1 << mode) - 1);
      send_value(v, i == len - 1 && len < BLK);
    end
  endtask

  // directed: extremes of value, end marker, size classes
  task automatic test_extremes();
    send_value(32'hFFFF_FFFF, 1'b1);
    send_value(32'd0, 1'b1);
    for (int i = 0; i < 4; i++) send_value(32'd255 + 32'(i), 1'b0);
    send_value(32'd65535, 1'b0);
    send_value(32'd65536, 1'b1);
    send_value(32'h5555_5555, 1'b0);
    send_value(32'hAAAA_AAAA, 1'b1);
  endtask

  // one large value then zeros: chain gaps force extra exceptions
  task automatic test_forced_exceptions();
    for (int i = 0; i < BLK; i++) send_value(i == 0 ? 32'd1000 : 32'd0, 1'b0);
  endtask

  task automatic test_limits();
    logic [5:0] lims [5] = '{6'd0, 6'd32, 6'd1, 6'd20, 6'd3};
    foreach (lims[j]) begin
      write_limit(lims[j]);
      send_block(BLK, -1);
      send_block(BLK, $urandom_range(1, 12));
      send_block($urandom_range(1, BLK - 1), -1);
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    holdoff = 600;
    send_block(BLK, -1);
    send_block(BLK, 4);
  endtask

  task automatic test_random(int target);
    int len;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) write_limit(6'($urandom_range(0, 32)));
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, BLK - 1) : BLK;
      send_block(len, ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, 20));
    end
  endtask

  // result stall generator
  always @(negedge clk) begin
    if (holdoff > 0) begin
      holdoff <= holdoff - 1;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_burst > 0) begin
      stall_burst <= stall_burst - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_burst <= $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each result transfer with the oldest expected word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (exp_words.size() == 0) begin
        $error("unexpected word %h", out_word);
        errors++;
      end else begin
        if (out_word !== exp_words[0]) begin
          $error("word: expected %h, actual %h", exp_words[0], out_word);
          errors++;
        end
        if (out_last_word !== exp_lasts[0]) begin
          $error("last_word: expected %b, actual %b", exp_lasts[0], out_last_word);
          errors++;
        end
        void'(exp_words.pop_front());
        void'(exp_lasts.pop_front());
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else if (idle_count >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else
      idle_count <= idle_count + 1;
  end

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_value = '0; in_end_of_stream = 1'b0;
    out_stall = 1'b0; cfg_valid = 1'b0; cfg_exception_limit = '0;
    errors = 0; items_sent = 0; blocks_done = 0; words_seen = 0; idle_count = 0;
    holdoff = 0; quiet = 0; stall_burst = 0; blk_fill = 0; exc_limit = ExcLimitRst;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_extremes();
    test_forced_exceptions();
    test_limits();
    test_backpressure();
    test_random(440);
    write_limit(6'd3);
    quiet = 1;
    test_random(520);
    send_value($urandom, 1'b1);
    drain();

    $display("Covered %0d values in %0d blocks, %0d words checked, limits 0 to 32.",
             items_sent, blocks_done, words_seen);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
design/pfd_pkg.sv
design/pfordelta_block_encoder_core.sv
sim/tb.sv
